>>> design/gra_pkg.sv
`timescale 1ns / 1ps
package gra_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int COORD_BITS_DEF  = 12;
  localparam int DIM_BITS        = 13;
  localparam int ORDER_BITS      = 32;
  localparam int CFG_DATA_BITS   = 32;
  localparam int CFG_ADDR_BITS   = 3;

  localparam logic [DIM_BITS-1:0] ATLAS_RESET = 13'd512;

  // function codes of a request
  localparam logic FUNC_RESTART = 1'b0;
  localparam logic FUNC_ALLOC   = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // register index, taken from paddr bit 2
  localparam logic REG_ATLAS_W = 1'b0;
  localparam logic REG_ATLAS_H = 1'b1;

  typedef struct packed {
    logic load;
    logic seed;
    logic scan;
    logic decide;
    logic split;
    logic wr_right;
    logic wr_bot;
    logic out_load;
  } gra_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic no_fit;
    logic overflow;
  } gra_stat_t;

endpackage

>>> design/gra_ram.sv
`timescale 1ns / 1ps
module gra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/gra_ctrl.sv
`timescale 1ns / 1ps
module gra_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_func,
  output logic              out_valid,
  input  logic              out_stall,
  output gra_pkg::gra_cmd_t cmd,
  input  gra_pkg::gra_stat_t stat
);
  import gra_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SEED     = 8'b0000_0010,
    S_SCAN     = 8'b0000_0100,
    S_DECIDE   = 8'b0000_1000,
    S_SPLIT    = 8'b0001_0000,
    S_WR_RIGHT = 8'b0010_0000,
    S_WR_BOT   = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_func == FUNC_ALLOC) ? S_SCAN : S_SEED;
        end
      end
      S_SEED: begin
        cmd.seed  = 1'b1;
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = stat.no_fit ? S_DONE : S_SPLIT;
      end
      S_SPLIT: begin
        cmd.split = 1'b1;
        state_nxt = stat.overflow ? S_DONE : S_WR_RIGHT;
      end
      S_WR_RIGHT: begin
        cmd.wr_right = 1'b1;
        state_nxt    = S_WR_BOT;
      end
      S_WR_BOT: begin
        cmd.wr_bot = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        // wait until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> design/gra_dpath.sv
`timescale 1ns / 1ps
module gra_dpath #(
  parameter int TABLE_DEPTH = gra_pkg::TABLE_DEPTH_DEF,
  parameter int COORD_BITS  = gra_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gra_pkg::gra_cmd_t            cmd,
  output gra_pkg::gra_stat_t           stat,
  input  logic [gra_pkg::DIM_BITS-1:0] in_req_width,
  input  logic [gra_pkg::DIM_BITS-1:0] in_req_height,
  input  logic [gra_pkg::DIM_BITS-1:0] atlas_width,
  input  logic [gra_pkg::DIM_BITS-1:0] atlas_height,
  output logic [COORD_BITS-1:0]        out_place_x,
  output logic [COORD_BITS-1:0]        out_place_y,
  output logic [1:0]                   out_status
);
  import gra_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  // seed dimensions saturate at the coordinate range
  localparam logic [DIM_BITS-1:0] SAT_DIM =
    (COORD_BITS < DIM_BITS) ? DIM_BITS'(1 << COORD_BITS) : '1;

  typedef struct packed {
    logic [ORDER_BITS-1:0] order;
    logic                  is_wide;
    logic [DIM_BITS-1:0]   tall;
    logic [DIM_BITS-1:0]   wide;
    logic [COORD_BITS-1:0] top;
    logic [COORD_BITS-1:0] left;
  } entry_t;

  localparam int EW = $bits(entry_t);

  // free table: valid bits in flops, payload in ram
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [ORDER_BITS-1:0]  ins_cnt_r, ins_cnt_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic          ram_re;
  logic [EW-1:0] ram_rdata;

  // scan
  logic [CW-1:0] scan_addr_r;
  logic          rd_pend_r;
  logic [AW-1:0] rd_idx_r;
  entry_t        rd_e;
  logic          rd_v, rd_fit, rd_free, t_better, w_better;

  logic [DIM_BITS-1:0] rw_r, rh_r;
  logic                t_found_r, w_found_r;
  entry_t              t_e_r, w_e_r;
  logic [AW-1:0]       t_idx_r, w_idx_r;
  logic                f0v_r, f1v_r;
  logic [AW-1:0]       f0_r, f1_r;

  // decision and split
  logic [DIM_BITS-1:0] t_slack, w_slack;
  logic                pick_tall;
  entry_t              pick_e_r;
  logic [AW-1:0]       pick_idx_r;

  logic [DIM_BITS-1:0] rem_w, rem_h;
  logic                cut_vert;
  entry_t              rt_e, bt_e, rt_e_r, bt_e_r;
  logic                rt_ok, bt_ok, rt_ok_r, bt_ok_r;
  logic [AW-1:0]       first_slot, second_slot;
  logic [AW-1:0]       rt_slot_r, bt_slot_r;
  logic                overflow;

  // seed
  logic [DIM_BITS-1:0] seed_w, seed_h;
  logic                seed_ok;
  entry_t              seed_e;

  logic [1:0]            res_status_r;
  logic [COORD_BITS-1:0] res_x_r, res_y_r;
  logic [COORD_BITS-1:0] out_x_r, out_y_r;
  logic [1:0]            out_status_r;

  gra_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan_addr_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // ---------------- scan ----------------
  assign ram_re = cmd.scan && (scan_addr_r != CW'(TABLE_DEPTH));

  always_comb begin
    rd_e     = entry_t'(ram_rdata);
    rd_v     = valid_r[rd_idx_r];
    rd_fit   = rd_pend_r && rd_v && (rd_e.wide >= rw_r) && (rd_e.tall >= rh_r);
    rd_free  = rd_pend_r && !rd_v;
    t_better = rd_fit && !rd_e.is_wide &&
               (!t_found_r || (rd_e.wide < t_e_r.wide) ||
                ((rd_e.wide == t_e_r.wide) && (rd_e.order < t_e_r.order)));
    w_better = rd_fit && rd_e.is_wide &&
               (!w_found_r || (rd_e.tall < w_e_r.tall) ||
                ((rd_e.tall == w_e_r.tall) && (rd_e.order < w_e_r.order)));
  end

  assign stat.scan_done = rd_pend_r && (rd_idx_r == AW'(TABLE_DEPTH - 1));
  assign stat.no_fit    = !t_found_r && !w_found_r;
  assign stat.overflow  = overflow;

  // ---------------- decision ----------------
  always_comb begin
    t_slack   = t_e_r.wide - rw_r;
    w_slack   = w_e_r.tall - rh_r;
    pick_tall = t_found_r && (!w_found_r || (t_slack <= w_slack));
  end

  // ---------------- guillotine split ----------------
  always_comb begin
    rem_w    = pick_e_r.wide - rw_r;
    rem_h    = pick_e_r.tall - rh_r;
    cut_vert = rem_w > rem_h;

    rt_e         = '0;
    rt_e.left    = pick_e_r.left + COORD_BITS'(rw_r);
    rt_e.top     = pick_e_r.top;
    rt_e.wide    = rem_w;
    rt_e.tall    = cut_vert ? pick_e_r.tall : rh_r;
    rt_e.is_wide = rt_e.wide > rt_e.tall;

    bt_e         = '0;
    bt_e.left    = pick_e_r.left;
    bt_e.top     = pick_e_r.top + COORD_BITS'(rh_r);
    bt_e.wide    = cut_vert ? rw_r : pick_e_r.wide;
    bt_e.tall    = rem_h;
    bt_e.is_wide = bt_e.wide > bt_e.tall;

    rt_ok = (rt_e.wide != '0) && (rt_e.tall != '0);
    bt_ok = (bt_e.wide != '0) && (bt_e.tall != '0);

    // lowest two free slots once the picked slot is released
    if (!f0v_r) begin
      first_slot  = pick_idx_r;
      second_slot = pick_idx_r;
    end else if (pick_idx_r < f0_r) begin
      first_slot  = pick_idx_r;
      second_slot = f0_r;
    end else begin
      first_slot  = f0_r;
      second_slot = (f1v_r && (f1_r < pick_idx_r)) ? f1_r : pick_idx_r;
    end

    overflow = rt_ok && bt_ok && !f0v_r;
  end

  // ---------------- seed ----------------
  always_comb begin
    seed_w         = (atlas_width > SAT_DIM) ? SAT_DIM : atlas_width;
    seed_h         = (atlas_height > SAT_DIM) ? SAT_DIM : atlas_height;
    seed_ok        = (seed_w != '0) && (seed_h != '0);
    seed_e         = '0;
    seed_e.wide    = seed_w;
    seed_e.tall    = seed_h;
    seed_e.is_wide = seed_w > seed_h;
  end

  // ---------------- table write port ----------------
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = seed_e;
    valid_nxt   = valid_r;
    ins_cnt_nxt = ins_cnt_r;
    if (cmd.seed) begin
      valid_nxt   = '0;
      valid_nxt[0] = seed_ok;
      ram_we      = seed_ok;
      ins_cnt_nxt = seed_ok ? ORDER_BITS'(1) : '0;
    end else if (cmd.wr_right) begin
      valid_nxt[pick_idx_r] = 1'b0;
      ram_waddr       = rt_slot_r;
      ram_wdata       = rt_e_r;
      ram_wdata.order = ins_cnt_r;
      if (rt_ok_r) begin
        ram_we               = 1'b1;
        valid_nxt[rt_slot_r] = 1'b1;
        ins_cnt_nxt          = ins_cnt_r + 1'b1;
      end
    end else if (cmd.wr_bot) begin
      ram_waddr       = bt_slot_r;
      ram_wdata       = bt_e_r;
      ram_wdata.order = ins_cnt_r;
      if (bt_ok_r) begin
        ram_we               = 1'b1;
        valid_nxt[bt_slot_r] = 1'b1;
        ins_cnt_nxt          = ins_cnt_r + 1'b1;
      end
    end
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      ins_cnt_r   <= '0;
      rd_pend_r   <= 1'b0;
      scan_addr_r <= '0;
      t_found_r   <= 1'b0;
      w_found_r   <= 1'b0;
      f0v_r       <= 1'b0;
      f1v_r       <= 1'b0;
    end else begin
      valid_r   <= valid_nxt;
      ins_cnt_r <= ins_cnt_nxt;
      rd_pend_r <= ram_re;
      if (cmd.load) begin
        scan_addr_r <= '0;
        t_found_r   <= 1'b0;
        w_found_r   <= 1'b0;
        f0v_r       <= 1'b0;
        f1v_r       <= 1'b0;
      end else begin
        if (ram_re) begin
          scan_addr_r <= scan_addr_r + 1'b1;
        end
        if (t_better) begin
          t_found_r <= 1'b1;
        end
        if (w_better) begin
          w_found_r <= 1'b1;
        end
        if (rd_free) begin
          if (!f0v_r) begin
            f0v_r <= 1'b1;
          end else if (!f1v_r) begin
            f1v_r <= 1'b1;
          end
        end
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    rd_idx_r <= scan_addr_r[AW-1:0];
    if (cmd.load) begin
      rw_r         <= in_req_width;
      rh_r         <= in_req_height;
      res_status_r <= ST_OK;
      res_x_r      <= '0;
      res_y_r      <= '0;
    end
    if (t_better) begin
      t_e_r   <= rd_e;
      t_idx_r <= rd_idx_r;
    end
    if (w_better) begin
      w_e_r   <= rd_e;
      w_idx_r <= rd_idx_r;
    end
    if (rd_free) begin
      if (!f0v_r) begin
        f0_r <= rd_idx_r;
      end else if (!f1v_r) begin
        f1_r <= rd_idx_r;
      end
    end
    if (cmd.decide) begin
      pick_e_r   <= pick_tall ? t_e_r : w_e_r;
      pick_idx_r <= pick_tall ? t_idx_r : w_idx_r;
      if (stat.no_fit) begin
        res_status_r <= ST_NO_SPACE;
      end
    end
    if (cmd.split) begin
      rt_e_r    <= rt_e;
      bt_e_r    <= bt_e;
      rt_ok_r   <= rt_ok;
      bt_ok_r   <= bt_ok;
      rt_slot_r <= first_slot;
      bt_slot_r <= rt_ok ? second_slot : first_slot;
      if (overflow) begin
        res_status_r <= ST_OVERFLOW;
      end else begin
        res_x_r <= pick_e_r.left;
        res_y_r <= pick_e_r.top;
      end
    end
    if (cmd.out_load) begin
      out_x_r      <= res_x_r;
      out_y_r      <= res_y_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_place_x = out_x_r;
  assign out_place_y = out_y_r;
  assign out_status  = out_status_r;

endmodule

>>> design/guillotine_rect_allocator.sv
`timescale 1ns / 1ps
// allocate: the free table ram is scanned one slot per cycle, then the best fit is picked
//   and split; the next request is taken only after the result is loaded for output
// restart: the free table is seeded with the atlas size, then the result is loaded for output
// the output register holds a result while the next request is taken
// synchronous active-low reset: table empty, atlas registers at 512, no result pending
module guillotine_rect_allocator #(
  parameter int TABLE_DEPTH = gra_pkg::TABLE_DEPTH_DEF,
  parameter int COORD_BITS  = gra_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_func,
  input  logic [gra_pkg::DIM_BITS-1:0]      in_req_width,
  input  logic [gra_pkg::DIM_BITS-1:0]      in_req_height,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [COORD_BITS-1:0]             out_place_x,
  output logic [COORD_BITS-1:0]             out_place_y,
  output logic [1:0]                        out_status,

  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [gra_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [gra_pkg::CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [gra_pkg::CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                              cfg_pready
);
  import gra_pkg::*;

  logic [DIM_BITS-1:0] atlas_w_r, atlas_h_r;
  logic                cfg_wr;
  gra_cmd_t            cmd;
  gra_stat_t           stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atlas_w_r <= ATLAS_RESET;
      atlas_h_r <= ATLAS_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_ATLAS_W: atlas_w_r <= cfg_pwdata[DIM_BITS-1:0];
        REG_ATLAS_H: atlas_h_r <= cfg_pwdata[DIM_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_ATLAS_W: cfg_prdata = CFG_DATA_BITS'(atlas_w_r);
      REG_ATLAS_H: cfg_prdata = CFG_DATA_BITS'(atlas_h_r);
      default:     cfg_prdata = '0;
    endcase
  end

  gra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  gra_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COORD_BITS  (COORD_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_req_width  (in_req_width),
    .in_req_height (in_req_height),
    .atlas_width   (atlas_w_r),
    .atlas_height  (atlas_h_r),
    .out_place_x   (out_place_x),
    .out_place_y   (out_place_y),
    .out_status    (out_status)
  );

endmodule
